/* hw/rtl/md4_hash_engine_macros.svh */
// assertion macros for the md4 hash engine
// expects clk and rst_n in the scope where the macros are used
`ifndef MD4_HASH_ENGINE_MACROS_SVH
`define MD4_HASH_ENGINE_MACROS_SVH

// same-cycle implication, quiet during reset
`define MD4_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define MD4_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/md4_pkg.sv */
// md4 hash engine package: microcode types, control store, round helpers
// no dependencies
package md4_pkg;

    localparam logic [31:0] IV_A     = 32'h6745_2301;
    localparam logic [31:0] IV_B     = 32'hefcd_ab89;
    localparam logic [31:0] IV_C     = 32'h98ba_dcfe;
    localparam logic [31:0] IV_D     = 32'h1032_5476;
    localparam logic [31:0] K_ROUND2 = 32'h5a82_7999;
    localparam logic [31:0] K_ROUND3 = 32'h6ed9_eba1;
    localparam logic [7:0]  PAD_MARK = 8'h80;
    localparam logic [5:0]  LEN_POS  = 6'd56;
    localparam logic [5:0]  LAST_RND = 6'd47;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_PAD,
        OP_ZERO,
        OP_ZSTART,
        OP_LEN_LO,
        OP_LEN_HI,
        OP_PRIME,
        OP_ROUND,
        OP_FOLD,
        OP_EMIT,
        OP_INIT
    } op_t;

    typedef enum logic [3:0] {
        C_NONE,
        C_FULL,
        C_LAST,
        C_FIN,
        C_PADW15,
        C_WP15,
        C_LONG,
        C_WP13,
        C_RND47,
        C_EMIT_DONE
    } cnd_t;

    typedef logic [3:0] upc_t;

    // microprogram addresses
    localparam upc_t S_IDLE   = 4'd0;
    localparam upc_t S_CHKFIN = 4'd1;
    localparam upc_t S_PAD    = 4'd2;
    localparam upc_t S_ZFILL  = 4'd3;
    localparam upc_t S_CHKLEN = 4'd4;
    localparam upc_t S_ZSET   = 4'd5;
    localparam upc_t S_ZLOW   = 4'd6;
    localparam upc_t S_LEN    = 4'd7;
    localparam upc_t S_LENHI  = 4'd8;
    localparam upc_t S_PRIME  = 4'd9;
    localparam upc_t S_ROUND  = 4'd10;
    localparam upc_t S_FOLD   = 4'd11;
    localparam upc_t S_EMIT   = 4'd12;
    localparam upc_t S_INIT   = 4'd13;

    typedef struct packed {
        op_t  op;
        cnd_t cnd;
        upc_t tgt;
        cnd_t cnd2;
        upc_t tgt2;
        upc_t nxt;
        logic use_ret;
        logic ld_ret;
        upc_t ret;
    } uword_t;

    typedef struct packed {
        logic full;
        logic last;
        logic fin;
        logic padw15;
        logic wp15;
        logic long_msg;
        logic wp13;
        logic rnd47;
        logic emit_done;
    } md4_flags_t;

    function automatic uword_t md4_uw(op_t op, cnd_t cnd, upc_t tgt, cnd_t cnd2, upc_t tgt2,
                                      upc_t nxt, logic use_ret, logic ld_ret, upc_t ret);
        uword_t w;
        w.op      = op;
        w.cnd     = cnd;
        w.tgt     = tgt;
        w.cnd2    = cnd2;
        w.tgt2    = tgt2;
        w.nxt     = nxt;
        w.use_ret = use_ret;
        w.ld_ret  = ld_ret;
        w.ret     = ret;
        return w;
    endfunction

    // control store
    function automatic uword_t md4_rom(upc_t a);
        uword_t w;
        case (a)
            S_IDLE:   w = md4_uw(OP_ACCEPT, C_FULL, S_PRIME, C_LAST, S_PAD,
                                 S_IDLE, 1'b0, 1'b1, S_CHKFIN);
            S_CHKFIN: w = md4_uw(OP_NOP, C_FIN, S_PAD, C_NONE, S_IDLE,
                                 S_IDLE, 1'b0, 1'b0, S_IDLE);
            S_PAD:    w = md4_uw(OP_PAD, C_PADW15, S_CHKLEN, C_NONE, S_IDLE,
                                 S_ZFILL, 1'b0, 1'b0, S_IDLE);
            S_ZFILL:  w = md4_uw(OP_ZERO, C_WP15, S_CHKLEN, C_NONE, S_IDLE,
                                 S_ZFILL, 1'b0, 1'b0, S_IDLE);
            S_CHKLEN: w = md4_uw(OP_NOP, C_LONG, S_PRIME, C_NONE, S_IDLE,
                                 S_LEN, 1'b0, 1'b1, S_ZSET);
            S_ZSET:   w = md4_uw(OP_ZSTART, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_ZLOW, 1'b0, 1'b0, S_IDLE);
            S_ZLOW:   w = md4_uw(OP_ZERO, C_WP13, S_LEN, C_NONE, S_IDLE,
                                 S_ZLOW, 1'b0, 1'b0, S_IDLE);
            S_LEN:    w = md4_uw(OP_LEN_LO, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_LENHI, 1'b0, 1'b0, S_IDLE);
            S_LENHI:  w = md4_uw(OP_LEN_HI, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_PRIME, 1'b0, 1'b1, S_EMIT);
            S_PRIME:  w = md4_uw(OP_PRIME, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_ROUND, 1'b0, 1'b0, S_IDLE);
            S_ROUND:  w = md4_uw(OP_ROUND, C_RND47, S_FOLD, C_NONE, S_IDLE,
                                 S_ROUND, 1'b0, 1'b0, S_IDLE);
            S_FOLD:   w = md4_uw(OP_FOLD, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_IDLE, 1'b1, 1'b0, S_IDLE);
            S_EMIT:   w = md4_uw(OP_EMIT, C_EMIT_DONE, S_INIT, C_NONE, S_IDLE,
                                 S_EMIT, 1'b0, 1'b0, S_IDLE);
            S_INIT:   w = md4_uw(OP_INIT, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_IDLE, 1'b0, 1'b0, S_IDLE);
            default:  w = md4_uw(OP_NOP, C_NONE, S_IDLE, C_NONE, S_IDLE,
                                 S_IDLE, 1'b0, 1'b0, S_IDLE);
        endcase
        return w;
    endfunction

    // message word index for step i
    function automatic logic [3:0] md4_xidx(logic [5:0] i);
        logic [3:0] x;
        case (i[5:4])
            2'd1:    x = {i[1:0], i[3:2]};
            2'd2:    x = {i[0], i[1], i[2], i[3]};
            default: x = i[3:0];
        endcase
        return x;
    endfunction

    function automatic logic [4:0] md4_shift(logic [1:0] r, logic [1:0] j);
        logic [4:0] s;
        case ({r, j})
            4'b00_00: s = 5'd3;
            4'b00_01: s = 5'd7;
            4'b00_10: s = 5'd11;
            4'b00_11: s = 5'd19;
            4'b01_00: s = 5'd3;
            4'b01_01: s = 5'd5;
            4'b01_10: s = 5'd9;
            4'b01_11: s = 5'd13;
            4'b10_00: s = 5'd3;
            4'b10_01: s = 5'd9;
            4'b10_10: s = 5'd11;
            4'b10_11: s = 5'd15;
            default:  s = 5'd3;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] md4_rotl(logic [31:0] v, logic [4:0] s);
        logic [63:0] w;
        w = {v, v} << s;
        return w[63:32];
    endfunction

endpackage

/* hw/rtl/md4_if.sv */
// stream interfaces for the md4 hash engine: message bytes in, digest words out
// no dependencies
interface md4_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface md4_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_number;
    logic        final_word;

    modport source (output valid, output digest_word, output word_number,
                    output final_word, input ready);
    modport sink   (input valid, input digest_word, input word_number,
                    input final_word, output ready);
endinterface

/* hw/rtl/md4_sequencer.sv */
// md4 microcode sequencer: step counter, return register, control store lookup
// depends on md4_pkg
module md4_sequencer
    import md4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  md4_flags_t flags,
    output op_t        op
);

    upc_t   pc_reg, pc_next;
    upc_t   ret_reg, ret_next;
    uword_t uw;

    function automatic logic test(cnd_t c, md4_flags_t f);
        logic t;
        case (c)
            C_FULL:      t = f.full;
            C_LAST:      t = f.last;
            C_FIN:       t = f.fin;
            C_PADW15:    t = f.padw15;
            C_WP15:      t = f.wp15;
            C_LONG:      t = f.long_msg;
            C_WP13:      t = f.wp13;
            C_RND47:     t = f.rnd47;
            C_EMIT_DONE: t = f.emit_done;
            default:     t = 1'b0;
        endcase
        return t;
    endfunction

    assign uw = md4_rom(pc_reg);

    // next step
    always_comb
    begin
        if (test(uw.cnd, flags))
        begin
            pc_next = uw.tgt;
        end
        else if (test(uw.cnd2, flags))
        begin
            pc_next = uw.tgt2;
        end
        else if (uw.use_ret)
        begin
            pc_next = ret_reg;
        end
        else
        begin
            pc_next = uw.nxt;
        end
        ret_next = uw.ld_ret ? uw.ret : ret_reg;
    end

    // control output
    always_comb
    begin
        op = uw.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg  <= S_IDLE;
            ret_reg <= S_IDLE;
        end
        else
        begin
            pc_reg  <= pc_next;
            ret_reg <= ret_next;
        end
    end

endmodule

/* hw/rtl/md4_datapath.sv */
// md4 datapath: block buffer memory, byte gather, padding, round unit, chaining words
// depends on md4_pkg and the stream interfaces
module md4_datapath
    import md4_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    output md4_flags_t flags,
    md4_msg_if.sink    msg,
    md4_digest_if.source digest
);

    logic [31:0] mem [16];
    logic [31:0] rd_reg;

    logic [31:0] cv_reg [4];
    logic [31:0] cv_next [4];
    logic [63:0] count_reg, count_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [3:0]  wp_reg, wp_next;
    logic [1:0]  k_reg, k_next;
    logic        fin_reg, fin_next;

    logic        in_xfer, out_xfer;
    logic        we;
    logic [3:0]  wa, ra;
    logic [31:0] wd;
    logic [1:0]  lane;
    logic [31:0] merged, pad_word;
    logic [63:0] bits;
    logic [31:0] f, kc, t;
    logic [5:0]  rnd_inc;

    assign msg.ready  = (op == OP_ACCEPT);
    assign in_xfer    = msg.valid && msg.ready;
    assign digest.valid       = (op == OP_EMIT);
    assign digest.digest_word = cv_reg[k_reg];
    assign digest.word_number = k_reg;
    assign digest.final_word  = (k_reg == 2'd3);
    assign out_xfer   = digest.valid && digest.ready;

    assign lane    = count_reg[1:0];
    assign bits    = {count_reg[60:0], 3'b000};
    assign rnd_inc = rnd_reg + 6'd1;

    always_comb
    begin
        merged = acc_reg;
        merged[{lane, 3'b000} +: 8] = msg.data_byte;
        for (int j = 0; j < 4; j++)
        begin
            if (2'(j) < lane)
            begin
                pad_word[8*j +: 8] = acc_reg[8*j +: 8];
            end
            else if (2'(j) == lane)
            begin
                pad_word[8*j +: 8] = PAD_MARK;
            end
            else
            begin
                pad_word[8*j +: 8] = 8'h00;
            end
        end
    end

    // one md4 step
    always_comb
    begin
        case (rnd_reg[5:4])
            2'd0:
            begin
                f  = d_reg ^ (b_reg & (c_reg ^ d_reg));
                kc = 32'h0;
            end
            2'd1:
            begin
                f  = (b_reg & c_reg) | (d_reg & (b_reg | c_reg));
                kc = K_ROUND2;
            end
            default:
            begin
                f  = b_reg ^ c_reg ^ d_reg;
                kc = K_ROUND3;
            end
        endcase
        t = md4_rotl(a_reg + f + rd_reg + kc, md4_shift(rnd_reg[5:4], rnd_reg[1:0]));
    end

    always_comb
    begin
        we         = 1'b0;
        wa         = count_reg[5:2];
        wd         = merged;
        ra         = md4_xidx(rnd_inc);
        count_next = count_reg;
        acc_next   = acc_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        d_next     = d_reg;
        rnd_next   = rnd_reg;
        wp_next    = wp_reg;
        k_next     = k_reg;
        fin_next   = fin_reg;
        for (int i = 0; i < 4; i++)
        begin
            cv_next[i] = cv_reg[i];
        end
        case (op)
            OP_ACCEPT:
            begin
                if (in_xfer)
                begin
                    fin_next = msg.end_of_message;
                    if (msg.byte_present)
                    begin
                        we         = 1'b1;
                        acc_next   = merged;
                        count_next = count_reg + 64'd1;
                    end
                end
            end
            OP_PAD:
            begin
                we      = 1'b1;
                wd      = pad_word;
                wp_next = count_reg[5:2] + 4'd1;
            end
            OP_ZERO:
            begin
                we      = 1'b1;
                wa      = wp_reg;
                wd      = 32'h0;
                wp_next = wp_reg + 4'd1;
            end
            OP_ZSTART:
            begin
                wp_next = 4'd0;
            end
            OP_LEN_LO:
            begin
                we = 1'b1;
                wa = 4'd14;
                wd = bits[31:0];
            end
            OP_LEN_HI:
            begin
                we = 1'b1;
                wa = 4'd15;
                wd = bits[63:32];
            end
            OP_PRIME:
            begin
                ra       = md4_xidx(6'd0);
                rnd_next = 6'd0;
                a_next   = cv_reg[0];
                b_next   = cv_reg[1];
                c_next   = cv_reg[2];
                d_next   = cv_reg[3];
            end
            OP_ROUND:
            begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = t;
                rnd_next = rnd_inc;
            end
            OP_FOLD:
            begin
                cv_next[0] = cv_reg[0] + a_reg;
                cv_next[1] = cv_reg[1] + b_reg;
                cv_next[2] = cv_reg[2] + c_reg;
                cv_next[3] = cv_reg[3] + d_reg;
            end
            OP_EMIT:
            begin
                if (out_xfer)
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            OP_INIT:
            begin
                cv_next[0] = IV_A;
                cv_next[1] = IV_B;
                cv_next[2] = IV_C;
                cv_next[3] = IV_D;
                count_next = 64'd0;
                fin_next   = 1'b0;
                k_next     = 2'd0;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        flags.full      = in_xfer && msg.byte_present && (count_reg[5:0] == 6'd63);
        flags.last      = in_xfer && msg.end_of_message;
        flags.fin       = fin_reg;
        flags.padw15    = (count_reg[5:2] == 4'd15);
        flags.wp15      = (wp_reg == 4'd15);
        flags.long_msg  = (count_reg[5:0] >= LEN_POS);
        flags.wp13      = (wp_reg == 4'd13);
        flags.rnd47     = (rnd_reg == LAST_RND);
        flags.emit_done = out_xfer && (k_reg == 2'd3);
    end

    // block buffer, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_reg <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg[0] <= IV_A;
            cv_reg[1] <= IV_B;
            cv_reg[2] <= IV_C;
            cv_reg[3] <= IV_D;
            count_reg <= 64'd0;
            k_reg     <= 2'd0;
            fin_reg   <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                cv_reg[i] <= cv_next[i];
            end
            count_reg <= count_next;
            k_reg     <= k_next;
            fin_reg   <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        rnd_reg <= rnd_next;
        wp_reg  <= wp_next;
    end

endmodule

/* hw/rtl/md4_hash_engine.sv */
// md4 hash engine top level: microcode sequencer driving the hash datapath
// depends on md4_pkg, the stream interfaces, md4_sequencer, md4_datapath and the macro header
//
//   channel   dir   payload                                   transfer when
//   msg       in    data_byte, byte_present, end_of_message   valid && ready
//   digest    out   digest_word, word_number, final_word      valid && ready
//
// a byte that does not close a block leaves the sequencer in S_IDLE
// the 64th byte of a block holds msg.ready low while the shared round unit runs 48 steps
// an end-of-message transfer is followed by padding, zero fill and one or two compressions,
// then four digest transfers; digest stalls hold the sequencer
// rst_n loads the IV into the chaining words and clears the byte count; the block buffer needs no clearing
`include "md4_hash_engine_macros.svh"

module md4_hash_engine
    import md4_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    md4_msg_if.sink      msg,
    md4_digest_if.source digest
);

    op_t        op;
    md4_flags_t flags;

    md4_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    md4_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .flags  (flags),
        .msg    (msg),
        .digest (digest)
    );

    `MD4_ASSERT_NOW(a_in_out_excl, digest.valid, !msg.ready, "input open while digest pending")
    `MD4_ASSERT_NEXT(a_end_busy, msg.valid && msg.ready && msg.end_of_message, !msg.ready,
        "input open right after end of message")
    `MD4_ASSERT_NEXT(a_digest_ends, digest.valid && digest.ready && digest.final_word,
        !digest.valid, "digest continues past final word")

endmodule
